/* rtl/mm2_pkg.sv */
// ----------------------------------------------------------------------------
// mm2_pkg
// Shared constants, types and state codes for the MurmurHash2 string hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package mm2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam int unsigned QUEUE_DEPTH = 4;

  // one command per item that needs work in the back end
  typedef struct packed {
    logic        init;
    logic [31:0] init_val;
    logic        word_en;
    logic [31:0] word;
    logic        fin;
    logic        tail_en;
    logic [23:0] tail;
  } mm2_cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_K1,
    B_K2,
    B_H1,
    B_HX,
    B_TAIL,
    B_TX,
    B_FA,
    B_FB
  } mm2_bstate_t;

endpackage

`default_nettype wire

/* rtl/mm2_if.sv */
// ----------------------------------------------------------------------------
// mm2_if
// Valid/ready channels of the hasher: byte input, hash output, seed write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm2_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        is_last;
  logic [31:0] string_length;

  modport source (output valid, data_byte, byte_valid, is_last, string_length, input ready);
  modport sink   (input valid, data_byte, byte_valid, is_last, string_length, output ready);
endinterface

interface mm2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface mm2_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

`default_nettype wire

/* rtl/mm2_front.sv */
// ----------------------------------------------------------------------------
// mm2_front
// Takes bytes, holds the seed, gathers words and issues back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mm2_in_if.sink                 in_chan,
  mm2_cfg_if.sink                cfg_chan,
  input  wire logic              q_full,
  output logic                   q_push,
  output mm2_pkg::mm2_cmd_t      q_cmd
);
  import mm2_pkg::*;

  logic [31:0] seed_r;
  logic        in_string_r, in_string_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] gather_r, gather_nxt;

  logic        first;
  logic        accept;
  logic        active;
  logic [1:0]  pos_cur, pos_new;
  logic [23:0] gather_cur, gather_new;

  assign in_chan.ready  = ~q_full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid & in_chan.ready;
  assign active         = in_chan.byte_valid | in_chan.is_last;

  always_comb begin
    first      = ~in_string_r;
    pos_cur    = first ? 2'd0 : pos_r;
    gather_cur = first ? 24'd0 : gather_r;
    pos_new    = pos_cur;
    gather_new = gather_cur;

    q_cmd          = '0;
    q_cmd.init     = first;
    q_cmd.init_val = seed_r ^ in_chan.string_length;

    if (in_chan.byte_valid) begin
      if (pos_cur == 2'd3) begin
        q_cmd.word_en = 1'b1;
        q_cmd.word    = {in_chan.data_byte, gather_cur};
        pos_new       = 2'd0;
        gather_new    = 24'd0;
      end else begin
        case (pos_cur)
          2'd0:    gather_new[7:0]   = in_chan.data_byte;
          2'd1:    gather_new[15:8]  = in_chan.data_byte;
          2'd2:    gather_new[23:16] = in_chan.data_byte;
          default: gather_new        = gather_cur;
        endcase
        pos_new = pos_cur + 2'd1;
      end
    end

    q_cmd.fin     = in_chan.is_last;
    q_cmd.tail_en = (pos_new != 2'd0);
    q_cmd.tail    = gather_new;

    q_push = accept & active & (first | q_cmd.word_en | in_chan.is_last);

    in_string_nxt = in_string_r;
    pos_nxt       = pos_r;
    gather_nxt    = gather_r;
    if (accept && active) begin
      if (in_chan.is_last) begin
        in_string_nxt = 1'b0;
        pos_nxt       = 2'd0;
        gather_nxt    = 24'd0;
      end else begin
        in_string_nxt = 1'b1;
        pos_nxt       = pos_new;
        gather_nxt    = gather_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      in_string_r <= 1'b0;
      pos_r       <= '0;
      gather_r    <= '0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        seed_r <= cfg_chan.seed;
      end
      in_string_r <= in_string_nxt;
      pos_r       <= pos_nxt;
      gather_r    <= gather_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/mm2_queue.sv */
// ----------------------------------------------------------------------------
// mm2_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_queue #(
  parameter int unsigned DEPTH = mm2_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mm2_pkg::mm2_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output mm2_pkg::mm2_cmd_t      pop_cmd,
  output logic                   empty
);
  import mm2_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mm2_cmd_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mm2_back.sv */
// ----------------------------------------------------------------------------
// mm2_back
// Mix and finish sequencer around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire mm2_pkg::mm2_cmd_t cmd,
  output logic                   cmd_pop,
  mm2_out_if.source              out_chan
);
  import mm2_pkg::*;

  mm2_bstate_t state_r, state_nxt;
  mm2_cmd_t    cmd_r, cmd_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic [31:0] opnd;
  logic [31:0] prod;

  assign out_chan.valid      = ovalid_r;
  assign out_chan.hash_value = res_r;

  always_comb begin
    case (state_r)
      B_K1:    opnd = cmd_r.word;
      B_K2:    opnd = p_r ^ (p_r >> MIX_SHIFT);
      B_TAIL:  opnd = h_r ^ {8'd0, cmd_r.tail};
      B_FA:    opnd = h_r ^ (h_r >> FIN_SHIFT_A);
      default: opnd = h_r;
    endcase
  end

  assign prod = opnd * MIX_MUL;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    h_nxt      = h_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r & ~out_chan.ready;
    cmd_pop    = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.init) begin
            h_nxt = cmd.init_val;
          end
          if (cmd.word_en) begin
            state_nxt = B_K1;
          end else if (cmd.fin) begin
            state_nxt = cmd.tail_en ? B_TAIL : B_FA;
          end
        end
      end
      B_K1: begin
        p_nxt     = prod;
        state_nxt = B_K2;
      end
      B_K2: begin
        p_nxt     = prod;
        state_nxt = B_H1;
      end
      B_H1: begin
        k_nxt     = p_r;
        p_nxt     = prod;
        state_nxt = B_HX;
      end
      B_HX: begin
        h_nxt = p_r ^ k_r;
        if (cmd_r.fin) begin
          state_nxt = cmd_r.tail_en ? B_TAIL : B_FA;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_TAIL: begin
        p_nxt     = prod;
        state_nxt = B_TX;
      end
      B_TX: begin
        h_nxt     = p_r;
        state_nxt = B_FA;
      end
      B_FA: begin
        p_nxt     = prod;
        state_nxt = B_FB;
      end
      B_FB: begin
        if (!ovalid_r || out_chan.ready) begin
          res_nxt    = p_r ^ (p_r >> FIN_SHIFT_B);
          ovalid_nxt = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    h_r   <= h_nxt;
    p_r   <= p_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

/* rtl/murmur2_string_hash_top.sv */
// ----------------------------------------------------------------------------
// murmur2_string_hash_top
// Streaming 32-bit MurmurHash2 of byte strings, one byte per input transfer.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                         transfer
//   in_chan   in   data_byte, byte_valid, is_last, string_length   valid & ready
//   out_chan  out  hash_value                                      valid & ready
//   cfg_chan  in   seed                                            valid & ready
//
// Front end takes one byte per cycle while the command queue has room.
// Back end, one command at a time from idle (string start loads h there): a word
// runs K1-K2-H1-HX, the finish TAIL-TX if a tail, then FA-FB, on one shared multiplier.
// A finished hash waits in the output register while the next string runs.
// rst_n is synchronous, active low; seed resets to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_string_hash_top #(
  parameter int unsigned QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mm2_in_if.sink    in_chan,
  mm2_out_if.source out_chan,
  mm2_cfg_if.sink   cfg_chan
);
  import mm2_pkg::*;

  mm2_cmd_t push_cmd, pop_cmd;
  logic     push, pop, full, empty;

  mm2_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  mm2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  mm2_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_chan  (out_chan)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command popped from empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("pushed command lost");

endmodule

`default_nettype wire
